>>> src/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// shared types, sizes, request and status codes of the sorted list engine
// ----------------------------------------------------------------------------
package sle_pkg;

  // store geometry
  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 32;

  // fixed field widths of the transactions
  localparam int REQ_BITS  = 3;
  localparam int WORD_BITS = 32;
  localparam int POS_BITS  = 5;
  localparam int STS_BITS  = 2;

  // derived widths
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int PLACE_W   = $clog2(CAPACITY + 2);
  localparam int KEY_EXT   = (KEY_BITS > WORD_BITS) ? KEY_BITS : WORD_BITS;
  localparam int CMP_W     = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;
  localparam int PLACE_EXT = (PLACE_W > POS_BITS) ? PLACE_W : POS_BITS;

  // request codes
  localparam logic [REQ_BITS-1:0] REQ_INSERT     = 3'd0;
  localparam logic [REQ_BITS-1:0] REQ_REMOVE_VAL = 3'd1;
  localparam logic [REQ_BITS-1:0] REQ_FIND       = 3'd2;
  localparam logic [REQ_BITS-1:0] REQ_READ_AT    = 3'd3;
  localparam logic [REQ_BITS-1:0] REQ_REMOVE_AT  = 3'd4;
  localparam logic [REQ_BITS-1:0] REQ_CLEAR      = 3'd5;

  // status codes
  localparam logic [STS_BITS-1:0] STS_OK        = 2'd0;
  localparam logic [STS_BITS-1:0] STS_FULL      = 2'd1;
  localparam logic [STS_BITS-1:0] STS_NOT_FOUND = 2'd2;
  localparam logic [STS_BITS-1:0] STS_BAD_POS   = 2'd3;

  typedef logic [KEY_BITS-1:0] key_t;

  typedef struct packed {
    logic [REQ_BITS-1:0]  req_type;
    logic [WORD_BITS-1:0] key_value;
    logic [POS_BITS-1:0]  slot_number;
  } in_t;

  typedef struct packed {
    logic [STS_BITS-1:0]  status;
    logic                 found_flag;
    logic [POS_BITS-1:0]  place;
    logic [WORD_BITS-1:0] read_value;
    logic [POS_BITS-1:0]  fill_level;
  } out_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

  // key taken modulo 2^KEY_BITS
  function automatic key_t key_from_word(logic [WORD_BITS-1:0] w);
    logic [KEY_EXT-1:0] wide;
    wide = KEY_EXT'(w);
    return wide[KEY_BITS-1:0];
  endfunction

  function automatic logic [WORD_BITS-1:0] word_from_key(key_t k);
    logic [KEY_EXT-1:0] wide;
    wide = KEY_EXT'(k);
    return wide[WORD_BITS-1:0];
  endfunction

endpackage

>>> src/sle_ctrl.sv
// ----------------------------------------------------------------------------
// sle_ctrl
// request sequencer: capture, execute, result hand-off
// ----------------------------------------------------------------------------
module sle_ctrl import sle_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output dp_cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    cmd_o.capture = (state_q == ST_IDLE) && in_valid_i;
    // result register free, or emptied at this edge
    cmd_o.execute = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd_o.execute) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.execute || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> src/sle_dpath.sv
// ----------------------------------------------------------------------------
// sle_dpath
// row of key cells with per-cell comparators, shift network and result register
// ----------------------------------------------------------------------------
module sle_dpath import sle_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  dp_cmd_t cmd_i,
  input  in_t     in_i,
  output out_t    out_o
);

  key_t                  cells_q [CAPACITY];
  key_t                  cells_d [CAPACITY];
  logic [CNT_W-1:0]      count_q, count_d;

  // captured request and compare flags
  logic [REQ_BITS-1:0]   req_q;
  key_t                  key_q;
  logic [POS_BITS-1:0]   slot_q;
  logic [CAPACITY-1:0]   lt_q, lt_d;
  logic [CAPACITY-1:0]   eq_q, eq_d;

  out_t                  out_q, out_d;

  key_t                  key_in;
  logic [CAPACITY-1:0]   lt_prev, first, sd;
  logic                  found_v, slot_ok, full_v;
  logic                  do_ins, do_del;
  logic [CNT_W-1:0]      lower;
  logic [PLACE_W-1:0]    place_v;
  logic [PLACE_EXT-1:0]  place_ext;
  logic [CMP_W-1:0]      pos_m1;
  logic [CMP_W-1:0]      fill_ext;
  key_t                  rval;

  assign key_in = key_from_word(in_i.key_value);

  // compare every occupied cell with the incoming key
  always_comb begin
    for (int j = 0; j < CAPACITY; j++) begin
      lt_d[j] = (CNT_W'(j) < count_q) && (cells_q[j] < key_in);
      eq_d[j] = (CNT_W'(j) < count_q) && (cells_q[j] == key_in);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= in_i.req_type;
      key_q  <= key_in;
      slot_q <= in_i.slot_number;
      lt_q   <= lt_d;
      eq_q   <= eq_d;
    end
  end

  // lt_q is a prefix: the boundary cell is the insertion point
  always_comb begin
    lower = lt_q[CAPACITY-1] ? CNT_W'(CAPACITY) : '0;
    for (int j = 0; j < CAPACITY; j++) begin
      lt_prev[j] = (j == 0) ? 1'b1 : lt_q[(j == 0) ? 0 : j - 1];
      first[j]   = !lt_q[j] && lt_prev[j];
      if (first[j]) begin
        lower = lower | CNT_W'(j);
      end
    end
    found_v = |(eq_q & first);
    place_v = PLACE_W'(lower) + PLACE_W'(1);
  end

  // position checks for read and remove at position
  assign slot_ok = (slot_q != '0) && (CMP_W'(slot_q) <= CMP_W'(count_q));
  assign pos_m1  = CMP_W'(slot_q) - CMP_W'(1);
  assign rval    = cells_q[pos_m1[IDX_W-1:0]];
  assign full_v  = (count_q == CNT_W'(CAPACITY));

  assign do_ins = (req_q == REQ_INSERT) && !full_v;
  assign do_del = ((req_q == REQ_REMOVE_VAL) && found_v) ||
                  ((req_q == REQ_REMOVE_AT) && slot_ok);

  always_comb begin
    for (int j = 0; j < CAPACITY; j++) begin
      sd[j] = (req_q == REQ_REMOVE_AT) ? (CMP_W'(j) >= pos_m1) : !lt_q[j];
    end
  end

  // shift network
  always_comb begin
    for (int j = 0; j < CAPACITY; j++) begin
      cells_d[j] = cells_q[j];
      if (do_ins && !lt_q[j]) begin
        if (lt_prev[j]) begin
          cells_d[j] = key_q;
        end else begin
          cells_d[j] = cells_q[(j == 0) ? 0 : j - 1];
        end
      end else if (do_del && sd[j] && (j < CAPACITY - 1)) begin
        cells_d[j] = cells_q[(j < CAPACITY - 1) ? j + 1 : j];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (req_q == REQ_CLEAR) begin
      count_d = '0;
    end else if (do_ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_del) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // result fields
  always_comb begin
    out_d            = '0;
    place_ext        = PLACE_EXT'(place_v);
    fill_ext         = CMP_W'(count_d);
    out_d.fill_level = fill_ext[POS_BITS-1:0];
    case (req_q)
      REQ_INSERT: begin
        if (full_v) begin
          out_d.status = STS_FULL;
        end
      end
      REQ_REMOVE_VAL: begin
        if (!found_v) begin
          out_d.status = STS_NOT_FOUND;
        end
      end
      REQ_FIND: begin
        out_d.place      = place_ext[POS_BITS-1:0];
        out_d.found_flag = found_v;
        if (!found_v) begin
          out_d.status = STS_NOT_FOUND;
        end
      end
      REQ_READ_AT: begin
        if (slot_ok) begin
          out_d.read_value = word_from_key(rval);
        end else begin
          out_d.status = STS_BAD_POS;
        end
      end
      REQ_REMOVE_AT: begin
        if (!slot_ok) begin
          out_d.status = STS_BAD_POS;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      out_q <= out_d;
      for (int j = 0; j < CAPACITY; j++) begin
        cells_q[j] <= cells_d[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.execute) begin
      count_q <= count_d;
    end
  end

  assign out_o = out_q;

endmodule

>>> src/sorted_list_engine.sv
// ----------------------------------------------------------------------------
// sorted_list_engine
// bounded sorted key store with insert, remove, find, read and clear requests
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------
//  request | in        | in_valid_i / in_stall_o | in_i  (in_t)
//  result  | out       | out_valid_o / out_stall_i | out_o (out_t)
//
// a request is handled in a capture step, where the accept edge latches it
// together with one comparator result per key cell, and an execute step that
// updates the cell row and loads the result register
// the cell row is a chain of CAPACITY registers, each shifts up or down by one
// place in the execute step, so no walk over the store is needed
// a new request is taken while a finished result waits in the result register
// a stalled result holds the execute step until the result register is freed
// reset clears the sequencer, the result valid and the key count; cell
// contents are don't-care until written
// ----------------------------------------------------------------------------
module sorted_list_engine import sle_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  // request transactions
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  // result transactions
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  dp_cmd_t cmd;

  // sequencer: idle, then execute once the result register can take a value
  sle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // key cells, comparators, shift network and result register
  sle_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .in_i   (in_i),
    .out_o  (out_o)
  );

`ifndef ASSERT_OFF
  // an accepted transaction keeps the engine busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("engine not busy after request accept");

  // a new result only appears at the end of an execute step
  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result valid without a request in flight");

  // full is only reported with a full store
  a_full_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_o.status == STS_FULL)) |->
      (out_o.fill_level == POS_BITS'(CAPACITY)))
    else $error("store full reported below capacity");

  // the found flag and not-found status agree on find results
  a_find_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.found_flag) |-> (out_o.status == STS_OK))
    else $error("found flag with error status");
`endif

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sorted list engine: a scoreboard class keeps its
// own sorted key store, predicts one result per accepted request and compares
// every accepted result field by field, while directed and random request
// streams run against random idling and stalls on both channels
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sle_pkg::*;

  // request codes that the block ignores
  localparam logic [REQ_BITS-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_BITS-1:0] REQ_SPARE_7 = 3'd7;

  // run shape: total request transactions with a real code, tail without
  // idling, and the long result hold-off that backs the block up
  localparam int unsigned ITEM_TARGET   = 430;
  localparam int unsigned CALM_FROM     = 370;
  localparam int unsigned HOLD_AFTER    = 60;
  localparam int unsigned LONG_HOLD     = 64;
  localparam int unsigned SETTLE_CYCLES = 16;

  // --------------------------------------------------------------------------
  // scoreboard: mirrors the key store and holds the expected results in order
  // --------------------------------------------------------------------------
  class store_scoreboard;
    key_t        keys [CAPACITY];
    int unsigned fill;
    out_t        pending [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned peak_fill;
    int unsigned req_seen [8];
    int unsigned status_seen [4];

    function new();
      fill      = 0;
      errors    = 0;
      checked   = 0;
      peak_fill = 0;
      foreach (req_seen[i]) req_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // first slot whose key is not smaller than k
    function int unsigned lower_slot(key_t k);
      int unsigned i;
      i = 0;
      while (i < fill && k > keys[i]) i++;
      return i;
    endfunction

    function void delete_slot(int unsigned i);
      int unsigned j;
      for (j = i; j + 1 < fill; j++) keys[j] = keys[j + 1];
      fill--;
    endfunction

    // accepted request transaction: update the store, queue the result
    function void note_request(in_t r);
      out_t        res;
      key_t        k;
      int unsigned i;
      int unsigned j;
      int unsigned slot;
      res  = '0;
      k    = r.key_value[KEY_BITS-1:0];
      slot = r.slot_number;
      case (r.req_type)
        REQ_INSERT: begin
          if (fill >= CAPACITY) begin
            res.status = STS_FULL;
          end else begin
            i = lower_slot(k);
            for (j = fill; j > i; j--) keys[j] = keys[j - 1];
            keys[i] = k;
            fill++;
          end
        end
        REQ_REMOVE_VAL: begin
          i = lower_slot(k);
          if (i < fill && keys[i] == k) delete_slot(i);
          else res.status = STS_NOT_FOUND;
        end
        REQ_FIND: begin
          i = lower_slot(k);
          res.place = POS_BITS'(i + 1);
          if (i < fill && keys[i] == k) res.found_flag = 1'b1;
          else res.status = STS_NOT_FOUND;
        end
        REQ_READ_AT: begin
          if (slot >= 1 && slot <= fill) res.read_value = WORD_BITS'(keys[slot - 1]);
          else res.status = STS_BAD_POS;
        end
        REQ_REMOVE_AT: begin
          if (slot >= 1 && slot <= fill) delete_slot(slot - 1);
          else res.status = STS_BAD_POS;
        end
        REQ_CLEAR: fill = 0;
        default: ;
      endcase
      res.fill_level = POS_BITS'(fill);
      if (fill > peak_fill) peak_fill = fill;
      req_seen[r.req_type]++;
      status_seen[res.status]++;
      pending.push_back(res);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                  checked, name, got, want));
    endtask

    // accepted result transaction: compare with the oldest expectation
    task check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", checked));
      end else begin
        want = pending.pop_front();
        check_field("status", 32'(got.status), 32'(want.status));
        check_field("found_flag", 32'(got.found_flag), 32'(want.found_flag));
        check_field("place", 32'(got.place), 32'(want.place));
        check_field("read_value", 32'(got.read_value), 32'(want.read_value));
        check_field("fill_level", 32'(got.fill_level), 32'(want.fill_level));
      end
      checked++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block under test
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_i        = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_o;

  store_scoreboard sb;

  // stimulus progress, shared with the result stall process
  int unsigned issued    = 0;
  bit          calm_tail = 1'b0;
  bit          hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  sorted_list_engine dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  // hard stop in case a handshake never completes
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // monitor: both channels sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_ni) begin
      // a request transaction completes on valid with no stall
      if (in_valid_i && in_stall_o === 1'b0) sb.note_request(in_i);
      if (out_valid_o === 1'b1 && !out_stall_i) sb.check_result(out_o);
    end
  end

  // --------------------------------------------------------------------------
  // request generation
  // --------------------------------------------------------------------------
  function automatic in_t make_request(logic [REQ_BITS-1:0] op, key_t k,
                                       logic [POS_BITS-1:0] slot);
    in_t r;
    r.req_type    = op;
    r.key_value   = WORD_BITS'(k);
    r.slot_number = slot;
    return r;
  endfunction

  // keys lean toward stored values, small duplicates and the range ends so
  // that finds and value removes hit as well as miss
  function automatic key_t pick_key();
    int unsigned sel;
    key_t        k;
    sel = $urandom_range(0, 99);
    if (sel < 35 && sb.fill != 0) begin
      k = sb.keys[$urandom_range(0, sb.fill - 1)];
    end else if (sel < 45 && sb.fill != 0) begin
      // just past a stored key, mostly absent
      k = sb.keys[$urandom_range(0, sb.fill - 1)] + key_t'(1);
    end else if (sel < 68) begin
      k = key_t'($urandom_range(0, 15));
    end else if (sel < 82) begin
      case ($urandom_range(0, 3))
        0:       k = '0;
        1:       k = key_t'(1);
        2:       k = '1;
        default: k = {{(KEY_BITS-1){1'b1}}, 1'b0};
      endcase
    end else begin
      k = key_t'($urandom());
    end
    return k;
  endfunction

  // mostly a live position, otherwise anything the field can carry
  function automatic logic [POS_BITS-1:0] pick_slot();
    if (sb.fill != 0 && $urandom_range(0, 99) < 75)
      return POS_BITS'($urandom_range(1, sb.fill));
    return POS_BITS'($urandom_range(0, 31));
  endfunction

  function automatic in_t random_request(logic [REQ_BITS-1:0] op);
    return make_request(op, pick_key(), pick_slot());
  endfunction

  function automatic logic [REQ_BITS-1:0] pick_op();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 32) return REQ_INSERT;
    if (sel < 48) return REQ_REMOVE_VAL;
    if (sel < 68) return REQ_FIND;
    if (sel < 84) return REQ_READ_AT;
    if (sel < 97) return REQ_REMOVE_AT;
    return REQ_CLEAR;
  endfunction

  // --------------------------------------------------------------------------
  // request driver: called at a falling edge, returns at a falling edge
  // --------------------------------------------------------------------------
  task automatic idle_gap(int unsigned cycles);
    in_valid_i <= 1'b0;
    in_i       <= make_request(REQ_BITS'($urandom_range(0, 7)), key_t'($urandom()),
                               POS_BITS'($urandom_range(0, 31)));
    repeat (cycles) @(negedge clk);
  endtask

  task automatic send(in_t r);
    in_valid_i <= 1'b1;
    in_i       <= r;
    // payload holds until the block takes it
    do @(posedge clk); while (in_stall_o !== 1'b0);
    if (r.req_type <= REQ_CLEAR) issued++;
    if (issued >= CALM_FROM) calm_tail = 1'b1;
    @(negedge clk);
    if (!calm_tail && $urandom_range(0, 99) < 18) idle_gap($urandom_range(1, 12));
  endtask

  // edges of every field and every special case, filling to capacity on the way
  task automatic run_directed();
    key_t seed_keys [16];
    seed_keys = '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h5, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h5, 32'h3, 32'hAAAA_AAAA, 32'h5555_5555, 32'h1, 32'hFFFF_FFFE,
                  32'h100, 32'h100, 32'h2, 32'h9};
    // empty store: misses and bad positions
    send(make_request(REQ_FIND, 32'h7, 5'd0));
    send(make_request(REQ_REMOVE_VAL, 32'h0, 5'd0));
    send(make_request(REQ_READ_AT, 32'hFFFF_FFFF, 5'd1));
    send(make_request(REQ_REMOVE_AT, 32'h0, 5'd31));
    // fill with extremes and duplicates, then one insert too many
    foreach (seed_keys[i]) send(make_request(REQ_INSERT, seed_keys[i], 5'd16));
    send(make_request(REQ_INSERT, 32'h4, 5'd0));
    // duplicate key reports its first position, absent key its insert point
    send(make_request(REQ_FIND, 32'h5, 5'd0));
    send(make_request(REQ_FIND, 32'h6, 5'd31));
    send(make_request(REQ_FIND, 32'hFFFF_FFFF, 5'd0));
    send(make_request(REQ_READ_AT, 32'h0, 5'd16));
    send(make_request(REQ_READ_AT, 32'h0, 5'd17));
    send(make_request(REQ_READ_AT, 32'h0, 5'd0));
    send(make_request(REQ_REMOVE_VAL, 32'h5, 5'd0));
    send(make_request(REQ_REMOVE_VAL, 32'h6, 5'd0));
    send(make_request(REQ_REMOVE_AT, 32'h0, 5'd1));
    // unused codes change nothing
    send(make_request(REQ_SPARE_6, 32'hFFFF_FFFF, 5'd31));
    send(make_request(REQ_SPARE_7, 32'h0, 5'd1));
    send(make_request(REQ_CLEAR, 32'h1234_5678, 5'd7));
    send(make_request(REQ_READ_AT, 32'h0, 5'd1));
  endtask

  // one random sequence: mostly well-formed bursts, some noise
  task automatic run_sequence();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 14) begin
      // fill to capacity, then push past it
      while (sb.fill < CAPACITY) send(random_request(REQ_INSERT));
      repeat ($urandom_range(1, 2)) send(random_request(REQ_INSERT));
    end else if (pick < 25) begin
      // drain to empty, then one more remove
      while (sb.fill != 0)
        send(random_request(($urandom_range(0, 3) == 0) ? REQ_REMOVE_VAL : REQ_REMOVE_AT));
      send(random_request(($urandom_range(0, 1) == 0) ? REQ_REMOVE_VAL : REQ_REMOVE_AT));
    end else if (pick < 90) begin
      repeat ($urandom_range(4, 16)) send(random_request(pick_op()));
    end else if (pick < 94) begin
      send(random_request(REQ_CLEAR));
    end else begin
      // any code with any field content
      send(make_request(REQ_BITS'($urandom_range(0, 7)), key_t'($urandom()),
                        POS_BITS'($urandom_range(0, 31))));
    end
  endtask

  // --------------------------------------------------------------------------
  // result stall: random bursts, one long hold-off, none in the tail
  // --------------------------------------------------------------------------
  initial begin : result_stall
    wait (rst_ni === 1'b1);
    @(negedge clk);
    forever begin
      if (calm_tail) begin
        out_stall_i <= 1'b0;
        @(negedge clk);
      end else if (!hold_done && issued >= HOLD_AFTER) begin
        // long hold-off while requests keep coming, so the block backs up
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 24)) @(negedge clk);
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    sb = new();
    repeat (9) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    run_directed();
    while (issued < ITEM_TARGET) run_sequence();
    in_valid_i <= 1'b0;

    // let every expected result come out, then watch for strays
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("requests: %0d insert, %0d remove value, %0d find, %0d read, %0d remove at, %0d clear, %0d unused code",
             sb.req_seen[0], sb.req_seen[1], sb.req_seen[2], sb.req_seen[3],
             sb.req_seen[4], sb.req_seen[5], sb.req_seen[6] + sb.req_seen[7]);
    $display("outcomes: %0d ok, %0d full, %0d not found, %0d bad position; peak fill %0d, %0d results, %0d mismatches",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
             sb.peak_fill, sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
src/sle_pkg.sv
src/sle_ctrl.sv
src/sle_dpath.sv
src/sorted_list_engine.sv
dv/tb.sv
